### hw/rtl/dtdiff_pkg.sv
// Shared types, widths and constants for the Gregorian date difference block.
// Used by dtdiff_daynum, dtdiff_compare and date_difference_days.
// No dependencies.
`timescale 1ns / 1ps

package dtdiff_pkg;

	// Field widths of the input and result words.
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int COUNT_W  = 22;

	// A day number of a 14-bit year stays below 2^23.
	localparam int DAYNUM_W = 23;

	// Width of a cumulative month count (at most 366).
	localparam int CUM_W    = 9;

	// Width of year plus a small offset, before the constant divisions.
	localparam int YSUM_W   = YEAR_W + 1;

	// Days in a common year.
	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

	// Division of a 15-bit value by 100: multiply by ceil(2^19 / 100), shift by 19.
	localparam int          RECIP100_W = 13;
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam int          SHIFT_100  = 19;
	localparam int          PROD100_W  = YSUM_W + RECIP100_W;
	localparam int          Q100_W     = PROD100_W - SHIFT_100;

	// Division by 400 is a shift by 4 and a division by 25:
	// multiply by ceil(2^15 / 25), shift by 15.
	localparam int          SIXT_W    = YSUM_W - 4;
	localparam int          RECIP25_W = 11;
	localparam logic [10:0] RECIP_25  = 11'd1311;
	localparam int          SHIFT_25  = 15;
	localparam int          PROD25_W  = SIXT_W + RECIP25_W;
	localparam int          Q400_W    = PROD25_W - SHIFT_25;

	// Width of a quotient multiplied back for the divisibility checks.
	localparam int CHECK_W = 16;

	// Saturation value of the day count.
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Days before the first of each month in a common year; month codes
	// zero and one give none, codes above twelve give the whole year.
	localparam logic [CUM_W-1:0] CUM_COMMON [16] = '{
		9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
	};

	// Input word: two dates.
	typedef struct packed {
		logic [YEAR_W-1:0]  first_year;
		logic [MONTH_W-1:0] first_month;
		logic [DAY_W-1:0]   first_day;
		logic [YEAR_W-1:0]  second_year;
		logic [MONTH_W-1:0] second_month;
		logic [DAY_W-1:0]   second_day;
	} dtdiff_in_t;

	// Result word.
	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic               order_error;
	} dtdiff_out_t;

	// Load enables of the three day-number stages.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} dtdiff_stage_en_t;

	// Days before the given month; a leap year adds one from March on.
	function automatic logic [CUM_W-1:0] cum_days(input logic leap,
		input logic [MONTH_W-1:0] month);
		logic late;
		late = (month >= MONTH_W'(3));
		return CUM_COMMON[month] + CUM_W'(leap && late);
	endfunction

endpackage

### hw/rtl/dtdiff_daynum.sv
// Three-stage pipeline that turns one date into a running day number.
// Depends on dtdiff_pkg for widths, reciprocal constants and the month table.
`timescale 1ns / 1ps

module dtdiff_daynum (
	input  logic                              clk,
	input  dtdiff_pkg::dtdiff_stage_en_t      en,
	input  logic [dtdiff_pkg::YEAR_W-1:0]     year,
	input  logic [dtdiff_pkg::MONTH_W-1:0]    month,
	input  logic [dtdiff_pkg::DAY_W-1:0]      day,
	output logic [dtdiff_pkg::DAYNUM_W-1:0]   day_num
);

	// Stage 1 combinational terms.
	logic [dtdiff_pkg::YSUM_W-1:0]    yp3;
	logic [dtdiff_pkg::YSUM_W-1:0]    yp99;
	logic [dtdiff_pkg::YSUM_W-1:0]    yp399;
	logic [dtdiff_pkg::PROD100_W-1:0] prod100;
	logic [dtdiff_pkg::SIXT_W-1:0]    sixteenths;
	logic [dtdiff_pkg::PROD25_W-1:0]  prod400;
	logic [dtdiff_pkg::DAYNUM_W-1:0]  y365;

	// Stage 1 registers.
	logic [dtdiff_pkg::YEAR_W-1:0]    year_s1;
	logic [dtdiff_pkg::MONTH_W-1:0]   month_s1;
	logic [dtdiff_pkg::DAY_W-1:0]     day_s1;
	logic [dtdiff_pkg::DAYNUM_W-1:0]  y365_s1;
	logic [dtdiff_pkg::YSUM_W-3:0]    c4_s1;
	logic [dtdiff_pkg::Q100_W-1:0]    c100_s1;
	logic [dtdiff_pkg::Q400_W-1:0]    c400_s1;

	// Stage 2 combinational terms.
	logic [dtdiff_pkg::CHECK_W-1:0]   back100;
	logic [dtdiff_pkg::CHECK_W-1:0]   back400;
	logic                             div100;
	logic                             div400;
	logic                             leap;
	logic [dtdiff_pkg::DAYNUM_W-1:0]  base;

	// Stage 2 registers.
	logic [dtdiff_pkg::DAYNUM_W-1:0]  base_s2;
	logic                             leap_s2;
	logic [dtdiff_pkg::MONTH_W-1:0]   month_s2;
	logic [dtdiff_pkg::DAY_W-1:0]     day_s2;

	// Stage 3 register.
	logic [dtdiff_pkg::DAYNUM_W-1:0]  day_num_s3;

	// Stage 1: year length product and the ceiling quotients by 4, 100 and 400.
	always_comb begin
		yp3        = dtdiff_pkg::YSUM_W'(year) + dtdiff_pkg::YSUM_W'(3);
		yp99       = dtdiff_pkg::YSUM_W'(year) + dtdiff_pkg::YSUM_W'(99);
		yp399      = dtdiff_pkg::YSUM_W'(year) + dtdiff_pkg::YSUM_W'(399);
		prod100    = dtdiff_pkg::PROD100_W'(yp99) *
			dtdiff_pkg::PROD100_W'(dtdiff_pkg::RECIP_100);
		sixteenths = yp399[dtdiff_pkg::YSUM_W-1:4];
		prod400    = dtdiff_pkg::PROD25_W'(sixteenths) *
			dtdiff_pkg::PROD25_W'(dtdiff_pkg::RECIP_25);
		y365       = dtdiff_pkg::DAYNUM_W'(year) *
			dtdiff_pkg::DAYNUM_W'(dtdiff_pkg::DAYS_PER_YEAR);
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			year_s1  <= year;
			month_s1 <= month;
			day_s1   <= day;
			y365_s1  <= y365;
			c4_s1    <= yp3[dtdiff_pkg::YSUM_W-1:2];
			c100_s1  <= prod100[dtdiff_pkg::PROD100_W-1:dtdiff_pkg::SHIFT_100];
			c400_s1  <= prod400[dtdiff_pkg::PROD25_W-1:dtdiff_pkg::SHIFT_25];
		end
	end

	// Stage 2: a ceiling quotient times its divisor equals the year exactly
	// when the year is divisible; sum the days of all earlier years.
	always_comb begin
		back100 = dtdiff_pkg::CHECK_W'(c100_s1) * dtdiff_pkg::CHECK_W'(100);
		back400 = dtdiff_pkg::CHECK_W'(c400_s1) * dtdiff_pkg::CHECK_W'(400);
		div100  = (back100 == dtdiff_pkg::CHECK_W'(year_s1));
		div400  = (back400 == dtdiff_pkg::CHECK_W'(year_s1));
		leap    = ((year_s1[1:0] == 2'b00) && !div100) || div400;
		base    = y365_s1 + dtdiff_pkg::DAYNUM_W'(c4_s1)
			+ dtdiff_pkg::DAYNUM_W'(c400_s1) - dtdiff_pkg::DAYNUM_W'(c100_s1);
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			base_s2  <= base;
			leap_s2  <= leap;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
		end
	end

	// Stage 3: add the months before this one and the day of the month.
	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			day_num_s3 <= base_s2
				+ dtdiff_pkg::DAYNUM_W'(dtdiff_pkg::cum_days(leap_s2, month_s2))
				+ dtdiff_pkg::DAYNUM_W'(day_s2);
		end
	end

	assign day_num = day_num_s3;

endmodule

### hw/rtl/dtdiff_compare.sv
// Final stage: orders two day numbers, subtracts and saturates the count.
// Depends on dtdiff_pkg for the result word type and widths.
`timescale 1ns / 1ps

module dtdiff_compare (
	input  logic                            clk,
	input  logic                            en,
	input  logic [dtdiff_pkg::DAYNUM_W-1:0] first_num,
	input  logic [dtdiff_pkg::DAYNUM_W-1:0] second_num,
	output dtdiff_pkg::dtdiff_out_t         result
);

	logic [dtdiff_pkg::DAYNUM_W-1:0] diff;
	logic                            reversed;
	dtdiff_pkg::dtdiff_out_t         next_result;
	dtdiff_pkg::dtdiff_out_t         result_s4;

	// A reversed pair flags an order error with a zero count; a count past
	// the field width saturates.
	always_comb begin
		reversed = (second_num < first_num);
		diff     = second_num - first_num;
		next_result.order_error = reversed;
		if (reversed) begin
			next_result.day_count = '0;
		end else if (diff[dtdiff_pkg::DAYNUM_W-1:dtdiff_pkg::COUNT_W] != '0) begin
			next_result.day_count = dtdiff_pkg::COUNT_MAX;
		end else begin
			next_result.day_count = diff[dtdiff_pkg::COUNT_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			result_s4 <= next_result;
		end
	end

	assign result = result_s4;

endmodule

### hw/rtl/date_difference_days.sv
// Top level of the Gregorian date difference block: valid chain, stall
// control and two day-number pipelines. Depends on dtdiff_pkg,
// dtdiff_daynum and dtdiff_compare.
//
//   channel | direction | handshake                   | word
//   dates   | in        | dates_valid / dates_ready   | dtdiff_in_t (two dates)
//   result  | out       | result_valid / result_ready | dtdiff_out_t (count, order flag)
//
// One word per cycle is taken and given while result_ready holds; from
// acceptance to result_valid a word passes reciprocal multiplies, year sum,
// month add, compare and subtract, each behind its own register.
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage holds its word while the stage after it is full and stalled,
// so empty stages fill and dates_ready falls only when all four are full.
`timescale 1ns / 1ps

module date_difference_days (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    dates_valid,
	output logic                    dates_ready,
	input  dtdiff_pkg::dtdiff_in_t  dates,
	output logic                    result_valid,
	input  logic                    result_ready,
	output dtdiff_pkg::dtdiff_out_t result
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic ready_s1;
	logic ready_s2;
	logic ready_s3;
	logic ready_s4;

	dtdiff_pkg::dtdiff_stage_en_t   stage_en;
	logic [dtdiff_pkg::DAYNUM_W-1:0] first_num;
	logic [dtdiff_pkg::DAYNUM_W-1:0] second_num;

	// A stage can load when it is empty or its word moves on this cycle.
	always_comb begin
		ready_s4 = !valid_s4 || result_ready;
		ready_s3 = !valid_s3 || ready_s4;
		ready_s2 = !valid_s2 || ready_s3;
		ready_s1 = !valid_s1 || ready_s2;
		stage_en.en_s1 = ready_s1;
		stage_en.en_s2 = ready_s2;
		stage_en.en_s3 = ready_s3;
	end

	assign dates_ready  = ready_s1;
	assign result_valid = valid_s4;

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= dates_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// Day number of the first date.
	dtdiff_daynum u_first (
		.clk     (clk),
		.en      (stage_en),
		.year    (dates.first_year),
		.month   (dates.first_month),
		.day     (dates.first_day),
		.day_num (first_num)
	);

	// Day number of the second date.
	dtdiff_daynum u_second (
		.clk     (clk),
		.en      (stage_en),
		.year    (dates.second_year),
		.month   (dates.second_month),
		.day     (dates.second_day),
		.day_num (second_num)
	);

	// Difference, order check and output register.
	dtdiff_compare u_compare (
		.clk        (clk),
		.en         (ready_s4),
		.first_num  (first_num),
		.second_num (second_num),
		.result     (result)
	);

`ifndef NO_ASSERTIONS
	// An accepted word always lands in the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dates_valid && dates_ready) |=> valid_s1)
		else $error("accepted word missing from stage 1");

	// A flagged order error never carries a count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.order_error) |-> (result.day_count == '0))
		else $error("order error with nonzero count");

	// Input stalls only when every stage is full and the output is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		!dates_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && !result_ready))
		else $error("input stalled with room in the pipeline");

	// A word held in stage 3 behind a blocked output stays there.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !ready_s4) |=> valid_s3)
		else $error("stage 3 word lost during stall");
`endif

endmodule
